>>> design/mrm_pkg.sv
// shared types and constants for the memory region map
// no dependencies; every other design file refers to it by scoped names
package mrm_pkg;

	localparam int TABLE_DEPTH = 32;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

	typedef enum logic [1:0] {
		CMD_APPEND  = 2'd0,
		CMD_RESERVE = 2'd1,
		CMD_MERGE   = 2'd2,
		CMD_READ    = 2'd3
	} cmd_code_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_MISS = 2'd1,
		ST_FULL = 2'd2
	} status_t;

	// what a cell loads at the next edge
	typedef enum logic [1:0] {
		CELL_HOLD = 2'd0,
		CELL_LOAD = 2'd1,
		CELL_UP   = 2'd2,
		CELL_DOWN = 2'd3
	} cell_op_t;

	typedef struct packed {
		logic        used;
		logic [31:0] base;
		logic [31:0] len;
	} entry_t;

	typedef struct packed {
		logic [1:0]  command;
		logic [31:0] region_addr;
		logic [31:0] region_size;
		logic        region_used;
		logic [4:0]  entry_index;
	} cmd_t;

	typedef struct packed {
		logic [1:0]  status;
		logic        entry_used_out;
		logic [31:0] entry_addr_out;
		logic [31:0] entry_size_out;
		logic [5:0]  entry_total;
	} rsp_t;

endpackage

>>> design/mrm_cmd_if.sv
// command channel of the memory region map
// depends on mrm_pkg for the payload type
interface mrm_cmd_if;
	logic          valid;
	logic          ready;
	mrm_pkg::cmd_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> design/mrm_rsp_if.sv
// response channel of the memory region map
// depends on mrm_pkg for the payload type
interface mrm_rsp_if;
	logic          valid;
	logic          ready;
	mrm_pkg::rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> design/memory_region_map_core.sv
// Memory region map: an ordered table of up to TABLE_DEPTH regions held in a row of
// cells that pass entries to their neighbours. One command is taken at a time. Append
// and read go through the exec and response states; reserve scans one entry per cycle,
// then shifts the row once per extra entry before writing; merge walks the table one
// step per cycle. A finished response waits in an output register while the next
// command is taken. No clearing pass after reset.
module memory_region_map_core (
	input  logic      clk,
	input  logic      arst_n,
	mrm_cmd_if.sink   cmd,
	mrm_rsp_if.source rsp
);

	localparam int DEPTH = mrm_pkg::TABLE_DEPTH;
	localparam int IW    = mrm_pkg::IDX_W;
	localparam int CW    = mrm_pkg::CNT_W;

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_EXEC  = 7'b0000010,
		S_SCAN  = 7'b0000100,
		S_SHIFT = 7'b0001000,
		S_WRITE = 7'b0010000,
		S_MERGE = 7'b0100000,
		S_RESP  = 7'b1000000
	} state_t;

	state_t            state_q;
	mrm_pkg::cmd_t     cmd_q;
	logic [CW-1:0]     count_q;
	logic [CW-1:0]     ptr_q;
	logic [CW-1:0]     pos_q;
	logic [31:0]       lead_q;
	logic [31:0]       trail_q;
	logic [1:0]        extra_q;
	logic [1:0]        shift_q;
	logic [1:0]        status_q;
	mrm_pkg::entry_t   read_q;
	logic              rsp_valid_q;
	mrm_pkg::rsp_t     rsp_data_q;

	mrm_pkg::entry_t   ent [DEPTH];
	mrm_pkg::cell_op_t cell_op [DEPTH];
	mrm_pkg::entry_t   cell_ld [DEPTH];

	mrm_pkg::entry_t cur, nxt, rd_ent;
	logic [32:0]     r_end, s_end, sum;
	logic            fits, room_fail, have_pair, pair_free, rd_in;
	logic [31:0]     lead, trail, sum_sat;
	logic [1:0]      extra;
	int              span_pos, trail_pos;

	assign cur       = ent[ptr_q[IW-1:0]];
	assign nxt       = ent[IW'(ptr_q + 1'b1)];
	assign r_end     = {1'b0, cur.base} + {1'b0, cur.len};
	assign s_end     = {1'b0, cmd_q.region_addr} + {1'b0, cmd_q.region_size};
	assign fits      = !cur.used && (cur.base <= cmd_q.region_addr) && (r_end >= s_end);
	assign lead      = cmd_q.region_addr - cur.base;
	assign trail     = r_end[31:0] - s_end[31:0];
	assign extra     = 2'(lead != '0) + 2'(trail != '0);
	assign room_fail = (int'(count_q) + int'(extra)) > DEPTH;
	assign have_pair = (int'(ptr_q) + 1) < int'(count_q);
	assign pair_free = !cur.used && !nxt.used;
	assign sum       = {1'b0, cur.len} + {1'b0, nxt.len};
	assign sum_sat   = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
	assign rd_in     = int'(cmd_q.entry_index) < int'(count_q);
	assign rd_ent    = ent[IW'(cmd_q.entry_index)];
	assign span_pos  = int'(pos_q) + int'(lead_q != '0);
	assign trail_pos = span_pos + 1;

	// per-cell operation for this cycle
	always_comb begin
		for (int k = 0; k < DEPTH; k++) begin
			cell_op[k] = mrm_pkg::CELL_HOLD;
			cell_ld[k] = '0;
			case (state_q)
				S_EXEC: begin
					if (cmd_q.command == mrm_pkg::CMD_APPEND && k == int'(count_q)) begin
						cell_op[k] = mrm_pkg::CELL_LOAD;
						cell_ld[k] = '{cmd_q.region_used, cmd_q.region_addr,
							cmd_q.region_size};
					end
				end
				S_SHIFT: begin
					if (k > int'(pos_q))
						cell_op[k] = mrm_pkg::CELL_UP;
				end
				S_WRITE: begin
					if (lead_q != '0 && k == int'(pos_q)) begin
						cell_op[k] = mrm_pkg::CELL_LOAD;
						cell_ld[k] = '{1'b0, cur.base, lead_q};
					end else if (k == span_pos) begin
						cell_op[k] = mrm_pkg::CELL_LOAD;
						cell_ld[k] = '{1'b1, cmd_q.region_addr, cmd_q.region_size};
					end else if (trail_q != '0 && k == trail_pos) begin
						cell_op[k] = mrm_pkg::CELL_LOAD;
						cell_ld[k] = '{1'b0, s_end[31:0], trail_q};
					end
				end
				S_MERGE: begin
					if (have_pair && pair_free) begin
						if (k == int'(ptr_q)) begin
							cell_op[k] = mrm_pkg::CELL_LOAD;
							cell_ld[k] = '{1'b0, cur.base, sum_sat};
						end else if (k > int'(ptr_q)) begin
							cell_op[k] = mrm_pkg::CELL_DOWN;
						end
					end
				end
				default: ;
			endcase
		end
	end

	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		mrm_cell u_cell (
			.clk   (clk),
			.op    (cell_op[g]),
			.load  (cell_ld[g]),
			.lower (ent[(g == 0) ? 0 : g - 1]),
			.upper (ent[(g == DEPTH - 1) ? g : g + 1]),
			.entry (ent[g])
		);
	end

	assign cmd.ready = (state_q == S_IDLE);
	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (state_q == S_RESP && (!rsp_valid_q || rsp.ready))
				rsp_valid_q <= 1'b1;
			else if (rsp.ready)
				rsp_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (cmd.valid) begin
						cmd_q   <= cmd.data;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					status_q <= mrm_pkg::ST_OK;
					read_q   <= '0;
					ptr_q    <= '0;
					case (cmd_q.command)
						mrm_pkg::CMD_APPEND: begin
							if (int'(count_q) < DEPTH)
								count_q <= count_q + 1'b1;
							else
								status_q <= mrm_pkg::ST_FULL;
							state_q <= S_RESP;
						end
						mrm_pkg::CMD_RESERVE: state_q <= S_SCAN;
						mrm_pkg::CMD_MERGE:   state_q <= S_MERGE;
						default: begin
							if (rd_in)
								read_q <= rd_ent;
							state_q <= S_RESP;
						end
					endcase
				end
				S_SCAN: begin
					if (ptr_q >= count_q) begin
						status_q <= mrm_pkg::ST_MISS;
						state_q  <= S_RESP;
					end else if (fits) begin
						if (room_fail) begin
							status_q <= mrm_pkg::ST_FULL;
							state_q  <= S_RESP;
						end else begin
							pos_q   <= ptr_q;
							lead_q  <= lead;
							trail_q <= trail;
							extra_q <= extra;
							shift_q <= extra;
							state_q <= (extra == '0) ? S_WRITE : S_SHIFT;
						end
					end else begin
						ptr_q <= ptr_q + 1'b1;
					end
				end
				S_SHIFT: begin
					shift_q <= shift_q - 1'b1;
					if (shift_q == 2'd1)
						state_q <= S_WRITE;
				end
				S_WRITE: begin
					// ptr_q still points at the split region, whose base cur holds
					count_q <= count_q + CW'(extra_q);
					state_q <= S_RESP;
				end
				S_MERGE: begin
					if (!have_pair)
						state_q <= S_RESP;
					else if (pair_free)
						count_q <= count_q - 1'b1;
					else
						ptr_q <= ptr_q + 1'b1;
				end
				S_RESP: begin
					if (!rsp_valid_q || rsp.ready) begin
						rsp_data_q  <= '{status_q, read_q.used, read_q.base, read_q.len,
							6'(count_q)};
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

>>> design/mrm_cell.sv
// one table entry of the region map, linked to its two neighbours
// depends on mrm_pkg for the entry and operation types
module mrm_cell (
	input  logic              clk,
	input  mrm_pkg::cell_op_t op,
	input  mrm_pkg::entry_t   load,
	input  mrm_pkg::entry_t   lower,
	input  mrm_pkg::entry_t   upper,
	output mrm_pkg::entry_t   entry
);

	mrm_pkg::entry_t entry_q;

	always_ff @(posedge clk) begin
		case (op)
			mrm_pkg::CELL_LOAD: entry_q <= load;
			mrm_pkg::CELL_UP:   entry_q <= lower;
			mrm_pkg::CELL_DOWN: entry_q <= upper;
			default:            entry_q <= entry_q;
		endcase
	end

	assign entry = entry_q;

endmodule
